[hdl/bblc_pkg.sv]
`default_nettype none
package bblc_pkg;

    // default coordinate width and queue depth
    localparam int COORD_BITS_DEF  = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    // fixed field widths
    localparam int KIND_BITS  = 3;
    localparam int FAIL_BITS  = 3;
    localparam int LIMIT_BITS = 32;
    localparam int MAG_BITS   = 16;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int CFG_IDX_BITS = 2;

    // atom kind codes
    localparam logic [KIND_BITS-1:0] KIND_N     = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_CA    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_C     = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_O     = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_OTHER = 3'd4;

    // failing bond codes
    localparam logic [FAIL_BITS-1:0] FAIL_NONE = 3'd0;
    localparam logic [FAIL_BITS-1:0] FAIL_C_O  = 3'd1;
    localparam logic [FAIL_BITS-1:0] FAIL_C_N  = 3'd2;
    localparam logic [FAIL_BITS-1:0] FAIL_N_CA = 3'd3;
    localparam logic [FAIL_BITS-1:0] FAIL_CA_C = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_C_O  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_C_N  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_N_CA = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CA_C = 2'd3;

    // limit reset values
    localparam logic [LIMIT_BITS-1:0] LIMIT_C_O_RST  = 32'd1638400;
    localparam logic [LIMIT_BITS-1:0] LIMIT_C_N_RST  = 32'd2359296;
    localparam logic [LIMIT_BITS-1:0] LIMIT_N_CA_RST = 32'd2359296;
    localparam logic [LIMIT_BITS-1:0] LIMIT_CA_C_RST = 32'd2621440;

    // one bond to check: magnitudes of the per-axis differences
    typedef struct packed {
        logic                 chk;
        logic                 big;
        logic [FAIL_BITS-1:0] code;
        logic [MAG_BITS-1:0]  mag_x;
        logic [MAG_BITS-1:0]  mag_y;
        logic [MAG_BITS-1:0]  mag_z;
    } t_bond;

    // classified word passed from front to back
    typedef struct packed {
        t_bond cn;
        t_bond near;
        logic  last;
    } t_check;

    // configured limits
    typedef struct packed {
        logic [LIMIT_BITS-1:0] c_o;
        logic [LIMIT_BITS-1:0] c_n;
        logic [LIMIT_BITS-1:0] n_ca;
        logic [LIMIT_BITS-1:0] ca_c;
    } t_limits;

endpackage
`default_nettype wire

[hdl/backbone_bond_length_check_unit.sv]
// backbone bond length checker, one atom word per cycle while the queue is not full
// a result word is registered once the last atom has passed the queue and the squares stage
// throughput: one atom per cycle; the queue between classifier and checker
// absorbs output stalls up to its depth before the input stalls
// reset (synchronous, active low): limits return to defaults, fragment state,
// queue and pipeline clear; no result is pending
`default_nettype none
module backbone_bond_length_check_unit #(
    parameter int COORD_BITS  = bblc_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = bblc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    // atom channel
    input  wire logic                                      i_valid,
    output logic                                           o_stall,
    input  wire logic        [bblc_pkg::KIND_BITS-1:0]     i_atom_kind,
    input  wire logic signed [COORD_BITS-1:0]              i_pos_x,
    input  wire logic signed [COORD_BITS-1:0]              i_pos_y,
    input  wire logic signed [COORD_BITS-1:0]              i_pos_z,
    input  wire logic                                      i_last_atom,
    // result channel
    output logic                                           o_valid,
    input  wire logic                                      i_stall,
    output logic                                           o_passed,
    output logic             [bblc_pkg::FAIL_BITS-1:0]     o_fail_kind,
    // configuration write channel
    input  wire logic                                      i_cfg_valid,
    output logic                                           o_cfg_ready,
    input  wire logic        [bblc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic        [bblc_pkg::LIMIT_BITS-1:0]    i_cfg_data
);

    localparam int QW = $bits(bblc_pkg::t_check);

    bblc_pkg::t_limits r_limits;
    bblc_pkg::t_check  fr_word, q_word;
    logic              q_full, q_empty, q_pop, in_accept;
    logic [QW-1:0]     q_rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign in_accept   = i_valid && !q_full;
    assign q_word      = bblc_pkg::t_check'(q_rd_data);

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.c_o  <= bblc_pkg::LIMIT_C_O_RST;
            r_limits.c_n  <= bblc_pkg::LIMIT_C_N_RST;
            r_limits.n_ca <= bblc_pkg::LIMIT_N_CA_RST;
            r_limits.ca_c <= bblc_pkg::LIMIT_CA_C_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bblc_pkg::REG_C_O:  r_limits.c_o  <= i_cfg_data;
                bblc_pkg::REG_C_N:  r_limits.c_n  <= i_cfg_data;
                bblc_pkg::REG_N_CA: r_limits.n_ca <= i_cfg_data;
                bblc_pkg::REG_CA_C: r_limits.ca_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classifier: tracks previous atoms and forms bond words
    bblc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_atom_kind (i_atom_kind),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_last_atom (i_last_atom),
        .o_word      (fr_word)
    );

    // queue between classifier and checker
    bblc_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_accept),
        .i_wr_data (fr_word),
        .o_full    (q_full),
        .i_rd_en   (q_pop),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // checker: squares, limit compares, first failure and result
    bblc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limits    (r_limits),
        .i_q_empty   (q_empty),
        .i_q_word    (q_word),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_passed    (o_passed),
        .o_fail_kind (o_fail_kind)
    );

endmodule
`default_nettype wire

[hdl/bblc_fifo.sv]
`default_nettype none
module bblc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_full,
    input  wire logic             i_rd_en,
    output logic      [WIDTH-1:0] o_rd_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [AW:0]      r_count;
    logic             wr_go, rd_go;

    // status
    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_go) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/bblc_front.sv]
`default_nettype none
module bblc_front #(
    parameter int COORD_BITS = bblc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_accept,
    input  wire logic        [bblc_pkg::KIND_BITS-1:0]  i_atom_kind,
    input  wire logic signed [COORD_BITS-1:0]           i_pos_x,
    input  wire logic signed [COORD_BITS-1:0]           i_pos_y,
    input  wire logic signed [COORD_BITS-1:0]           i_pos_z,
    input  wire logic                                   i_last_atom,
    output bblc_pkg::t_check                            o_word
);

    localparam int MB = bblc_pkg::MAG_BITS;
    localparam int EW = (COORD_BITS + 1 > MB) ? COORD_BITS + 1 : MB + 1;

    logic        [bblc_pkg::KIND_BITS-1:0] r_p1_kind, r_p2_kind;
    logic signed [COORD_BITS-1:0]          r_p1_x, r_p1_y, r_p1_z;
    logic signed [COORD_BITS-1:0]          r_p2_x, r_p2_y, r_p2_z;
    logic [MB:0] cn_x, cn_y, cn_z, nr_x, nr_y, nr_z;

    // magnitude of a coordinate difference, top bit flags 2^16 or more
    function automatic logic [MB:0] axis_mag(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        logic [EW-1:0]       e;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        e = EW'(m);
        return {|e[EW-1:MB], e[MB-1:0]};
    endfunction

    assign cn_x = axis_mag(r_p2_x, i_pos_x);
    assign cn_y = axis_mag(r_p2_y, i_pos_y);
    assign cn_z = axis_mag(r_p2_z, i_pos_z);
    assign nr_x = axis_mag(r_p1_x, i_pos_x);
    assign nr_y = axis_mag(r_p1_y, i_pos_y);
    assign nr_z = axis_mag(r_p1_z, i_pos_z);

    // classify the bonds closed by this atom
    always_comb begin
        o_word.last       = i_last_atom;
        o_word.cn.chk     = (r_p2_kind == bblc_pkg::KIND_C) &&
                            (i_atom_kind == bblc_pkg::KIND_N);
        o_word.cn.code    = bblc_pkg::FAIL_C_N;
        o_word.cn.big     = cn_x[MB] | cn_y[MB] | cn_z[MB];
        o_word.cn.mag_x   = cn_x[MB-1:0];
        o_word.cn.mag_y   = cn_y[MB-1:0];
        o_word.cn.mag_z   = cn_z[MB-1:0];
        o_word.near.big   = nr_x[MB] | nr_y[MB] | nr_z[MB];
        o_word.near.mag_x = nr_x[MB-1:0];
        o_word.near.mag_y = nr_y[MB-1:0];
        o_word.near.mag_z = nr_z[MB-1:0];
        priority if (r_p1_kind == bblc_pkg::KIND_C && i_atom_kind == bblc_pkg::KIND_O) begin
            o_word.near.chk  = 1'b1;
            o_word.near.code = bblc_pkg::FAIL_C_O;
        end else if (r_p1_kind == bblc_pkg::KIND_N && i_atom_kind == bblc_pkg::KIND_CA) begin
            o_word.near.chk  = 1'b1;
            o_word.near.code = bblc_pkg::FAIL_N_CA;
        end else if (r_p1_kind == bblc_pkg::KIND_CA && i_atom_kind == bblc_pkg::KIND_C) begin
            o_word.near.chk  = 1'b1;
            o_word.near.code = bblc_pkg::FAIL_CA_C;
        end else begin
            o_word.near.chk  = 1'b0;
            o_word.near.code = bblc_pkg::FAIL_NONE;
        end
    end

    // previous atom kinds, cleared at fragment end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_kind <= bblc_pkg::KIND_OTHER;
            r_p2_kind <= bblc_pkg::KIND_OTHER;
        end else if (i_accept) begin
            if (i_last_atom) begin
                r_p1_kind <= bblc_pkg::KIND_OTHER;
                r_p2_kind <= bblc_pkg::KIND_OTHER;
            end else begin
                r_p1_kind <= i_atom_kind;
                r_p2_kind <= r_p1_kind;
            end
        end
    end

    // previous atom positions
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p1_x <= i_pos_x;
            r_p1_y <= i_pos_y;
            r_p1_z <= i_pos_z;
            r_p2_x <= r_p1_x;
            r_p2_y <= r_p1_y;
            r_p2_z <= r_p1_z;
        end
    end

endmodule
`default_nettype wire

[hdl/bblc_back.sv]
`default_nettype none
module bblc_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire bblc_pkg::t_limits                     i_limits,
    input  wire logic                                  i_q_empty,
    input  wire bblc_pkg::t_check                      i_q_word,
    output logic                                       o_q_pop,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic                                       o_passed,
    output logic              [bblc_pkg::FAIL_BITS-1:0] o_fail_kind
);

    localparam int SQ  = bblc_pkg::SQ_BITS;
    localparam int SUM = bblc_pkg::SUM_BITS;
    localparam int FB  = bblc_pkg::FAIL_BITS;

    // squares stage
    logic           r_s1_v, r_s1_last;
    logic           r_cn_chk, r_cn_big, r_nr_chk, r_nr_big;
    logic [FB-1:0]  r_nr_code;
    logic [SQ-1:0]  r_cn_sx, r_cn_sy, r_cn_sz, r_nr_sx, r_nr_sy, r_nr_sz;
    // fragment and output state
    logic [FB-1:0]  r_first;
    logic           r_out_v, r_passed;
    logic [FB-1:0]  r_fail_kind;

    logic                             out_free, s1_take, s1_load;
    logic [SUM-1:0]                   cn_sum, nr_sum;
    logic [bblc_pkg::LIMIT_BITS-1:0]  nr_limit;
    logic                             cn_fail, nr_fail;
    logic [FB-1:0]                    hit, cur;

    // flow control
    assign out_free = !r_out_v || !i_stall;
    assign s1_take  = r_s1_v && (out_free || !r_s1_last);
    assign s1_load  = !r_s1_v || s1_take;
    assign o_q_pop  = s1_load && !i_q_empty;

    // limit for the bond from the previous atom
    always_comb begin
        unique case (r_nr_code)
            bblc_pkg::FAIL_C_O:  nr_limit = i_limits.c_o;
            bblc_pkg::FAIL_N_CA: nr_limit = i_limits.n_ca;
            bblc_pkg::FAIL_CA_C: nr_limit = i_limits.ca_c;
            default:             nr_limit = i_limits.c_o;
        endcase
    end

    // sum of squares and limit compare
    assign cn_sum  = SUM'(r_cn_sx) + SUM'(r_cn_sy) + SUM'(r_cn_sz);
    assign nr_sum  = SUM'(r_nr_sx) + SUM'(r_nr_sy) + SUM'(r_nr_sz);
    assign cn_fail = r_cn_chk && (r_cn_big || (cn_sum > SUM'(i_limits.c_n)));
    assign nr_fail = r_nr_chk && (r_nr_big || (nr_sum > SUM'(nr_limit)));

    // first failure wins, the bond two atoms back ranks ahead
    always_comb begin
        priority if (cn_fail) begin
            hit = bblc_pkg::FAIL_C_N;
        end else if (nr_fail) begin
            hit = r_nr_code;
        end else begin
            hit = bblc_pkg::FAIL_NONE;
        end
        cur = (r_first == bblc_pkg::FAIL_NONE) ? hit : r_first;
    end

    // squares pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_last <= i_q_word.last;
            r_cn_chk  <= i_q_word.cn.chk;
            r_cn_big  <= i_q_word.cn.big;
            r_nr_chk  <= i_q_word.near.chk;
            r_nr_big  <= i_q_word.near.big;
            r_nr_code <= i_q_word.near.code;
            r_cn_sx   <= i_q_word.cn.mag_x * i_q_word.cn.mag_x;
            r_cn_sy   <= i_q_word.cn.mag_y * i_q_word.cn.mag_y;
            r_cn_sz   <= i_q_word.cn.mag_z * i_q_word.cn.mag_z;
            r_nr_sx   <= i_q_word.near.mag_x * i_q_word.near.mag_x;
            r_nr_sy   <= i_q_word.near.mag_y * i_q_word.near.mag_y;
            r_nr_sz   <= i_q_word.near.mag_z * i_q_word.near.mag_z;
        end
    end

    // stage valid, latched failure and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_first <= bblc_pkg::FAIL_NONE;
            r_out_v <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_v <= !i_q_empty;
            end
            if (s1_take) begin
                r_first <= r_s1_last ? bblc_pkg::FAIL_NONE : cur;
            end
            if (s1_take && r_s1_last) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s1_take && r_s1_last) begin
            r_passed    <= (cur == bblc_pkg::FAIL_NONE);
            r_fail_kind <= cur;
        end
    end

    assign o_valid     = r_out_v;
    assign o_passed    = r_passed;
    assign o_fail_kind = r_fail_kind;

endmodule
`default_nettype wire

[sim/tb_backbone_bond_length_check_unit.sv]
module tb_backbone_bond_length_check_unit;

    localparam int     CW           = bblc_pkg::COORD_BITS_DEF;
    localparam longint COORD_MAX    = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN    = -(longint'(1) << (CW - 1));
    localparam int     PHASES       = 9;
    localparam int     ATOMS_PHASE  = 87;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     QUIET_LIMIT  = 5000;

    typedef logic [bblc_pkg::KIND_BITS-1:0]    t_kind;
    typedef logic [bblc_pkg::FAIL_BITS-1:0]    t_fail;
    typedef logic [bblc_pkg::LIMIT_BITS-1:0]   t_limit;
    typedef logic [bblc_pkg::CFG_IDX_BITS-1:0] t_idx;
    typedef logic [CW-1:0]                     t_coord;

    // kind codes above other, no bond uses them
    localparam t_kind KIND_SPARE = 3'd5;
    localparam t_kind KIND_JUNK  = 3'd7;

    // kinds in residue order
    localparam t_kind RES_ORDER [4] = '{bblc_pkg::KIND_N, bblc_pkg::KIND_CA,
                                        bblc_pkg::KIND_C, bblc_pkg::KIND_O};

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pos;

    typedef struct packed {
        t_kind kind;
        t_pos  pos;
        logic  last;
    } t_atom;

    typedef struct packed {
        logic  passed;
        t_fail fail_kind;
    } t_verdict;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    t_kind                       i_atom_kind;
    logic signed [CW-1:0]        i_pos_x;
    logic signed [CW-1:0]        i_pos_y;
    logic signed [CW-1:0]        i_pos_z;
    logic                        i_last_atom;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_passed;
    t_fail                       o_fail_kind;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    t_idx                        i_cfg_index;
    t_limit                      i_cfg_data;

    backbone_bond_length_check_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_atom_kind (i_atom_kind),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_last_atom (i_last_atom),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_passed    (o_passed),
        .o_fail_kind (o_fail_kind),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // pending atoms and verdicts still owed by the block
    t_atom    atom_q [$];
    t_verdict verdict_q [$];
    t_atom    atom_cur;
    t_verdict verdict_new;
    t_verdict verdict_exp;

    // chain tracker: two previous atoms, latched first failure, limits
    t_kind                hist1_kind;
    t_kind                hist2_kind;
    t_pos                 hist1_pos;
    t_pos                 hist2_pos;
    int                   hist_depth;
    t_fail                first_bad;
    bblc_pkg::t_limits    lim;

    bit run_en;
    int gap_pct;
    int stall_pct;
    int err_cnt;
    int atoms_queued;
    int atoms_in;
    int verdicts_seen;
    int verdicts_pass;
    int limit_writes;
    int quiet_cycles;
    int bad_tally [5];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // squared distance over limit, any axis of 65536 or more fails at once
    function automatic bit bond_too_long(input t_pos a, input t_pos b,
                                         input t_limit limit);
        longint          d [3];
        longint unsigned acc;
        int              k;
        d[0] = longint'($signed(a.x)) - longint'($signed(b.x));
        d[1] = longint'($signed(a.y)) - longint'($signed(b.y));
        d[2] = longint'($signed(a.z)) - longint'($signed(b.z));
        acc  = 0;
        for (k = 0; k < 3; k++) begin
            if (d[k] < 0) d[k] = -d[k];
            if (d[k] > 65535) return 1'b1;
            acc += longint'(d[k] * d[k]);
        end
        return acc > longint'(limit);
    endfunction

    function automatic void latch_fail(input t_fail code);
        if (first_bad == bblc_pkg::FAIL_NONE) first_bad = code;
    endfunction

    function automatic void clear_chain();
        hist1_kind = bblc_pkg::KIND_OTHER;
        hist2_kind = bblc_pkg::KIND_OTHER;
        hist1_pos  = '0;
        hist2_pos  = '0;
        hist_depth = 0;
        first_bad  = bblc_pkg::FAIL_NONE;
    endfunction

    // advance the chain by one atom; returns 1 when a verdict is due
    function automatic bit predict_verdict(input t_atom a, output t_verdict v);
        v = '0;
        // bond from two back ranks first
        if (hist_depth >= 2 && hist2_kind == bblc_pkg::KIND_C &&
            a.kind == bblc_pkg::KIND_N && bond_too_long(hist2_pos, a.pos, lim.c_n))
            latch_fail(bblc_pkg::FAIL_C_N);
        if (hist_depth >= 1) begin
            if (hist1_kind == bblc_pkg::KIND_C && a.kind == bblc_pkg::KIND_O &&
                bond_too_long(hist1_pos, a.pos, lim.c_o))
                latch_fail(bblc_pkg::FAIL_C_O);
            if (hist1_kind == bblc_pkg::KIND_N && a.kind == bblc_pkg::KIND_CA &&
                bond_too_long(hist1_pos, a.pos, lim.n_ca))
                latch_fail(bblc_pkg::FAIL_N_CA);
            if (hist1_kind == bblc_pkg::KIND_CA && a.kind == bblc_pkg::KIND_C &&
                bond_too_long(hist1_pos, a.pos, lim.ca_c))
                latch_fail(bblc_pkg::FAIL_CA_C);
        end
        hist2_kind = hist1_kind;
        hist2_pos  = hist1_pos;
        hist1_kind = a.kind;
        hist1_pos  = a.pos;
        if (hist_depth < 2) hist_depth++;
        if (a.last) begin
            v.passed    = (first_bad == bblc_pkg::FAIL_NONE);
            v.fail_kind = first_bad;
            clear_chain();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // driver: present queued atoms, random gaps between words
    always @(posedge i_clk) begin
        if (run_en) begin
            if (i_valid && !o_stall) begin
                atoms_in++;
                if (predict_verdict(atom_cur, verdict_new)) verdict_q.push_back(verdict_new);
            end
            if (!i_valid || !o_stall) begin
                if (atom_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    atom_cur    = atom_q.pop_front();
                    i_valid     <= 1'b1;
                    i_atom_kind <= atom_cur.kind;
                    i_pos_x     <= atom_cur.pos.x;
                    i_pos_y     <= atom_cur.pos.y;
                    i_pos_z     <= atom_cur.pos.z;
                    i_last_atom <= atom_cur.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check verdict words, random receiver stall
    always @(posedge i_clk) begin
        if (run_en) begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict word with none pending: passed %0d fail_kind %0d",
                           o_passed, o_fail_kind);
                    err_cnt++;
                end else begin
                    verdict_exp = verdict_q.pop_front();
                    verdicts_seen++;
                    if (verdict_exp.passed) verdicts_pass++;
                    if (verdict_exp.fail_kind <= bblc_pkg::FAIL_CA_C)
                        bad_tally[verdict_exp.fail_kind]++;
                    if (o_passed !== verdict_exp.passed) begin
                        $error("passed: expected %0d, got %0d", verdict_exp.passed, o_passed);
                        err_cnt++;
                    end
                    if (o_fail_kind !== verdict_exp.fail_kind) begin
                        $error("fail_kind: expected %0d, got %0d",
                               verdict_exp.fail_kind, o_fail_kind);
                        err_cnt++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (run_en) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: %0d atoms queued, %0d accepted, %0d verdicts pending",
                         atoms_queued, atoms_in, verdict_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_atom(input t_kind kind, input int x, input int y,
                             input int z, input bit last);
        t_atom a;
        a.kind  = kind;
        a.pos.x = x[CW-1:0];
        a.pos.y = y[CW-1:0];
        a.pos.z = z[CW-1:0];
        a.last  = last;
        atom_q.push_back(a);
        atoms_queued++;
    endtask

    function automatic t_coord nudge(input t_coord c, input int span);
        longint v;
        v = longint'($signed(c)) + longint'($urandom_range(2 * span)) - span;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[CW-1:0];
    endfunction

    // step size between neighbors, mostly near the bond limits
    function automatic int pick_span();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 700;
        if (r < 80) return 1100;
        if (r < 90) return 1600;
        if (r < 96) return 70000;
        return 0;
    endfunction

    // one fragment: clean residues, corrupted residues, or random atoms
    task automatic queue_fragment();
        t_kind                kinds [$];
        t_atom                a;
        int                   n;
        int                   i;
        int                   r;
        r = $urandom_range(99);
        if (r >= 88) begin
            n = $urandom_range(6, 1);
            for (i = 0; i < n; i++) begin
                a.kind  = t_kind'($urandom_range(7));
                a.pos.x = t_coord'($urandom);
                a.pos.y = t_coord'($urandom);
                a.pos.z = t_coord'($urandom);
                a.last  = (i == n - 1);
                atom_q.push_back(a);
                atoms_queued++;
            end
        end else begin
            n = $urandom_range(4, 1);
            for (i = 0; i < 4 * n; i++) begin
                if (r >= 60 && $urandom_range(9) == 0)
                    kinds.push_back(t_kind'($urandom_range(7)));
                else kinds.push_back(RES_ORDER[i % 4]);
            end
            if (r >= 60 && $urandom_range(2) == 0) begin
                n = $urandom_range(kinds.size(), 1);
                while (kinds.size() > n) void'(kinds.pop_back());
            end
            a.pos.x = t_coord'($urandom);
            a.pos.y = t_coord'($urandom);
            a.pos.z = t_coord'($urandom);
            for (i = 0; i < kinds.size(); i++) begin
                n       = pick_span();
                a.kind  = kinds[i];
                a.pos.x = nudge(a.pos.x, n);
                a.pos.y = nudge(a.pos.y, n);
                a.pos.z = nudge(a.pos.z, n);
                a.last  = (i == kinds.size() - 1);
                atom_q.push_back(a);
                atoms_queued++;
            end
        end
    endtask

    // wait for every atom and verdict, then for the pipeline to empty
    task automatic wait_drained();
        while (atoms_in != atoms_queued || verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_idx idx, input t_limit val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        unique case (idx)
            bblc_pkg::REG_C_O:  lim.c_o  = val;
            bblc_pkg::REG_C_N:  lim.c_n  = val;
            bblc_pkg::REG_N_CA: lim.n_ca = val;
            bblc_pkg::REG_CA_C: lim.ca_c = val;
            default: ;
        endcase
        limit_writes++;
    endtask

    task automatic set_idle(input int mode);
        unique case (mode)
            0: begin gap_pct = 13; stall_pct = 51; end
            1: begin gap_pct = 51; stall_pct = 13; end
            default: begin gap_pct = 0; stall_pct = 0; end
        endcase
    endtask

    // stimulus
    initial begin
        t_limit lv [4];
        int p;
        int r;
        int phase_end;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_atom_kind = bblc_pkg::KIND_OTHER;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_pos_z     = '0;
        i_last_atom = 1'b0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bblc_pkg::REG_C_O;
        i_cfg_data  = '0;
        run_en      = 1'b0;
        err_cnt     = 0;
        atoms_queued = 0;
        atoms_in    = 0;
        verdicts_seen = 0;
        verdicts_pass = 0;
        limit_writes = 0;
        quiet_cycles = 0;
        foreach (bad_tally[k]) bad_tally[k] = 0;
        lim.c_o  = bblc_pkg::LIMIT_C_O_RST;
        lim.c_n  = bblc_pkg::LIMIT_C_N_RST;
        lim.n_ca = bblc_pkg::LIMIT_N_CA_RST;
        lim.ca_c = bblc_pkg::LIMIT_CA_C_RST;
        clear_chain();
        set_idle(0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_en = 1'b1;

        // one-atom fragment passes
        push_atom(bblc_pkg::KIND_N, 0, 0, 0, 1'b1);
        // every bond at or just inside its default limit passes
        push_atom(bblc_pkg::KIND_N, 0, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_CA, 1536, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_C, 3136, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_O, 3136, 1280, 0, 1'b0);
        push_atom(bblc_pkg::KIND_N, 3136, 0, 1536, 1'b1);
        // n-ca one over, later ca-c failure must not replace it
        push_atom(bblc_pkg::KIND_N, 0, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_CA, 1537, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_C, 3537, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_O, 3537, 100, 0, 1'b0);
        push_atom(bblc_pkg::KIND_N, 3537, 0, 100, 1'b1);
        // c-o fails before c-n
        push_atom(bblc_pkg::KIND_C, 0, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_O, 1281, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_N, 0, 0, 1537, 1'b1);
        // c-n alone, across the oxygen
        push_atom(bblc_pkg::KIND_C, 0, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_O, 0, 1000, 0, 1'b0);
        push_atom(bblc_pkg::KIND_N, 0, 0, 1537, 1'b1);
        // ca-c alone, just inside its default limit
        push_atom(bblc_pkg::KIND_CA, 0, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_C, 0, 1601, 0, 1'b1);
        // opposite corners of the coordinate range
        push_atom(bblc_pkg::KIND_N, int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MIN), 1'b0);
        push_atom(bblc_pkg::KIND_CA, int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX), 1'b1);
        // unused kind codes break the chain
        push_atom(bblc_pkg::KIND_N, 0, 0, 0, 1'b0);
        push_atom(KIND_JUNK, 0, 0, 0, 1'b0);
        push_atom(bblc_pkg::KIND_CA, int'(COORD_MAX), 0, 0, 1'b0);
        push_atom(KIND_SPARE, 0, 0, 0, 1'b1);

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            set_idle(p / 3);
            if (p == 0) begin
                foreach (lv[k]) lv[k] = '1;
            end else if (p == 1) begin
                foreach (lv[k]) lv[k] = '0;
            end else if (p == 2) begin
                lv[0] = bblc_pkg::LIMIT_C_O_RST;
                lv[1] = bblc_pkg::LIMIT_C_N_RST;
                lv[2] = bblc_pkg::LIMIT_N_CA_RST;
                lv[3] = bblc_pkg::LIMIT_CA_C_RST;
            end else begin
                for (r = 0; r < 4; r++)
                    lv[r] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4000000, 600000);
            end
            write_limit(bblc_pkg::REG_C_O, lv[0]);
            write_limit(bblc_pkg::REG_C_N, lv[1]);
            write_limit(bblc_pkg::REG_N_CA, lv[2]);
            write_limit(bblc_pkg::REG_CA_C, lv[3]);
            if (p == 0) begin
                // largest axis difference that still squares within the limit
                push_atom(bblc_pkg::KIND_N, 0, 0, 0, 1'b0);
                push_atom(bblc_pkg::KIND_CA, 65535, 0, 0, 1'b1);
                push_atom(bblc_pkg::KIND_N, 0, 0, 0, 1'b0);
                push_atom(bblc_pkg::KIND_CA, 65536, 0, 0, 1'b1);
            end
            if (p == 1) begin
                // zero limit, zero distance still passes
                push_atom(bblc_pkg::KIND_CA, 5, 5, 5, 1'b0);
                push_atom(bblc_pkg::KIND_C, 5, 5, 5, 1'b1);
            end
            phase_end = atoms_queued + ATOMS_PHASE;
            while (atoms_queued < phase_end) queue_fragment();
        end

        wait_drained();
        $display("%0d atoms over %0d limit settings, %0d limit writes, %0d verdicts (%0d pass)",
                 atoms_in, PHASES + 1, limit_writes, verdicts_seen, verdicts_pass);
        $display("first failing bond seen: c-o %0d, c-n %0d, n-ca %0d, ca-c %0d",
                 bad_tally[bblc_pkg::FAIL_C_O], bad_tally[bblc_pkg::FAIL_C_N],
                 bad_tally[bblc_pkg::FAIL_N_CA], bad_tally[bblc_pkg::FAIL_CA_C]);
        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
